### hw/rtl/brainfuck_machine_unit_defines.svh
// ----------------------------------------------------------------------------
// brainfuck_machine_unit_defines.svh
// Assertion macros used by the machine's top level.
// ----------------------------------------------------------------------------
`ifndef BRAINFUCK_MACHINE_UNIT_DEFINES_SVH
`define BRAINFUCK_MACHINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BMU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brainfuck_machine_unit: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BMU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brainfuck_machine_unit: next-cycle check failed");

`endif

### hw/rtl/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg
// Types and constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bfm_pkg;

  // request modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // status codes
  localparam logic [1:0] ST_RUN       = 2'd0;
  localparam logic [1:0] ST_FIN       = 2'd1;
  localparam logic [1:0] ST_UNMATCHED = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // instruction characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;

  localparam int CELL_W = 32;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LATCH,
    DP_START,
    DP_EXEC,
    DP_SCAN_F,
    DP_SCAN_B,
    DP_CLR,
    DP_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic need_exec;
    logic need_clear;
    logic to_scan_f;
    logic to_scan_b;
    logic scan_end;
    logic clr_last;
  } dp_stat_t;

  typedef enum logic [2:0] {
    CS_INIT_CLR,
    CS_IDLE,
    CS_START,
    CS_EXEC,
    CS_SCAN_F,
    CS_SCAN_B,
    CS_RUN_CLR,
    CS_RESULT
  } ctl_state_t;

endpackage

`default_nettype wire

### hw/rtl/bfm_ctrl.sv
// ----------------------------------------------------------------------------
// bfm_ctrl
// Sequencing state machine: request intake, dispatch, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output bfm_pkg::dp_cmd_t       cmd,
  input  wire bfm_pkg::dp_stat_t stat
);

  bfm_pkg::ctl_state_t state, state_next;
  logic                rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bfm_pkg::CS_INIT_CLR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.op         = bfm_pkg::DP_NOP;
    req_stall      = 1'b1;
    rsp_valid_next = rsp_valid && rsp_stall;
    unique case (state)
      bfm_pkg::CS_INIT_CLR: begin
        cmd.op = bfm_pkg::DP_CLR;
        if (stat.clr_last) state_next = bfm_pkg::CS_IDLE;
      end
      bfm_pkg::CS_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.op     = bfm_pkg::DP_LATCH;
          state_next = bfm_pkg::CS_START;
        end
      end
      bfm_pkg::CS_START: begin
        cmd.op = bfm_pkg::DP_START;
        priority if (stat.need_exec) state_next = bfm_pkg::CS_EXEC;
        else if (stat.need_clear) state_next = bfm_pkg::CS_RUN_CLR;
        else state_next = bfm_pkg::CS_RESULT;
      end
      bfm_pkg::CS_EXEC: begin
        cmd.op = bfm_pkg::DP_EXEC;
        priority if (stat.to_scan_f) state_next = bfm_pkg::CS_SCAN_F;
        else if (stat.to_scan_b) state_next = bfm_pkg::CS_SCAN_B;
        else state_next = bfm_pkg::CS_RESULT;
      end
      bfm_pkg::CS_SCAN_F: begin
        cmd.op = bfm_pkg::DP_SCAN_F;
        if (stat.scan_end) state_next = bfm_pkg::CS_RESULT;
      end
      bfm_pkg::CS_SCAN_B: begin
        cmd.op = bfm_pkg::DP_SCAN_B;
        if (stat.scan_end) state_next = bfm_pkg::CS_RESULT;
      end
      bfm_pkg::CS_RUN_CLR: begin
        cmd.op = bfm_pkg::DP_CLR;
        if (stat.clr_last) state_next = bfm_pkg::CS_RESULT;
      end
      bfm_pkg::CS_RESULT: begin
        // output register free, or emptied this cycle
        if (!rsp_valid || !rsp_stall) begin
          cmd.op         = bfm_pkg::DP_LOAD;
          rsp_valid_next = 1'b1;
          state_next     = bfm_pkg::CS_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/bfm_dpath.sv
// ----------------------------------------------------------------------------
// bfm_dpath
// Program store, tape, pointers, bracket scan and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_dpath #(
  parameter int TAPE_SIZE  = 2048,
  parameter int PROG_DEPTH = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bfm_pkg::dp_cmd_t cmd,
  output bfm_pkg::dp_stat_t     stat,
  input  wire logic [1:0]       mode,
  input  wire logic [7:0]       prog_byte,
  output logic                  out_valid,
  output logic [7:0]            out_byte,
  output logic [1:0]            status
);

  localparam int AW = $clog2(PROG_DEPTH);
  localparam int PW = $clog2(PROG_DEPTH + 1);
  localparam int TW = $clog2(TAPE_SIZE);
  localparam int CW = bfm_pkg::CELL_W;
  localparam logic [PW-1:0] PROG_FULL = PW'(PROG_DEPTH);
  localparam logic [PW-1:0] ONE_P     = PW'(1);
  localparam logic [TW-1:0] TAPE_LAST = TW'(TAPE_SIZE - 1);
  localparam logic [TW-1:0] ONE_T     = TW'(1);

  // memories
  logic [7:0]    prog_mem [PROG_DEPTH];
  logic [CW-1:0] tape_mem [TAPE_SIZE];
  logic [7:0]    prog_q;
  logic [CW-1:0] tape_q;

  logic          prog_we, prog_re, tape_we, tape_re;
  logic [AW-1:0] prog_waddr, prog_raddr;
  logic [7:0]    prog_wdata;
  logic [TW-1:0] tape_waddr;
  logic [CW-1:0] tape_wdata;

  // control registers
  logic [PW-1:0] len, len_next;
  logic [PW-1:0] pc, pc_next;
  logic [TW-1:0] dp, dp_next;
  logic [1:0]    rs, rs_next;
  logic [TW-1:0] clr_cnt, clr_cnt_next;

  // payload registers
  logic [PW-1:0] k, k_next;
  logic [PW-1:0] depth, depth_next;
  logic [1:0]    mode_r, mode_r_next;
  logic [7:0]    byte_r, byte_r_next;
  logic          pend_ov, pend_ov_next;
  logic [7:0]    pend_ob, pend_ob_next;
  logic [1:0]    pend_st, pend_st_next;
  logic          out_valid_next;
  logic [7:0]    out_byte_next;
  logic [1:0]    status_next;

  logic [PW-1:0] pc_inc, pc_dec, k_inc, k_dec, depth_f, depth_b, tgt;
  logic          adv, err;

  assign pc_inc = pc + ONE_P;
  assign pc_dec = pc - ONE_P;
  assign k_inc  = k + ONE_P;
  assign k_dec  = k - ONE_P;

  // nesting depth after the scanned byte, forward and backward
  assign depth_f = (prog_q == bfm_pkg::CH_LBRK) ? depth + ONE_P :
                   (prog_q == bfm_pkg::CH_RBRK) ? depth - ONE_P : depth;
  assign depth_b = (prog_q == bfm_pkg::CH_RBRK) ? depth + ONE_P :
                   (prog_q == bfm_pkg::CH_LBRK) ? depth - ONE_P : depth;

  always_comb begin
    len_next       = len;
    pc_next        = pc;
    dp_next        = dp;
    rs_next        = rs;
    clr_cnt_next   = clr_cnt;
    k_next         = k;
    depth_next     = depth;
    mode_r_next    = mode_r;
    byte_r_next    = byte_r;
    pend_ov_next   = pend_ov;
    pend_ob_next   = pend_ob;
    pend_st_next   = pend_st;
    out_valid_next = out_valid;
    out_byte_next  = out_byte;
    status_next    = status;
    prog_we        = 1'b0;
    prog_waddr     = len[AW-1:0];
    prog_wdata     = byte_r;
    prog_re        = 1'b0;
    prog_raddr     = pc[AW-1:0];
    tape_we        = 1'b0;
    tape_waddr     = dp;
    tape_wdata     = tape_q;
    tape_re        = 1'b0;
    stat           = '0;
    adv            = 1'b0;
    err            = 1'b0;
    tgt            = pc_inc;

    unique case (cmd.op)
      bfm_pkg::DP_NOP: begin
      end
      bfm_pkg::DP_LATCH: begin
        mode_r_next = mode;
        byte_r_next = prog_byte;
      end
      bfm_pkg::DP_START: begin
        pend_ov_next = 1'b0;
        pend_ob_next = '0;
        pend_st_next = bfm_pkg::ST_RUN;
        unique case (mode_r)
          bfm_pkg::MODE_LOAD: begin
            if (len < PROG_FULL) begin
              prog_we  = 1'b1;
              len_next = len + ONE_P;
            end else begin
              pend_st_next = bfm_pkg::ST_FULL;
            end
          end
          bfm_pkg::MODE_STEP: begin
            priority if (rs != bfm_pkg::ST_RUN) begin
              pend_st_next = rs;
            end else if (pc >= len) begin
              rs_next      = bfm_pkg::ST_FIN;
              pend_st_next = bfm_pkg::ST_FIN;
            end else begin
              prog_re        = 1'b1;
              tape_re        = 1'b1;
              stat.need_exec = 1'b1;
            end
          end
          bfm_pkg::MODE_RUN: begin
            pc_next         = '0;
            dp_next         = '0;
            rs_next         = bfm_pkg::ST_RUN;
            stat.need_clear = 1'b1;
          end
          bfm_pkg::MODE_CLEAR: begin
            len_next = '0;
            pc_next  = '0;
            rs_next  = bfm_pkg::ST_RUN;
          end
        endcase
      end
      bfm_pkg::DP_EXEC: begin
        priority if (prog_q == bfm_pkg::CH_DOT) begin
          pend_ov_next = 1'b1;
          pend_ob_next = tape_q[7:0];
          adv          = 1'b1;
        end else if (prog_q == bfm_pkg::CH_PLUS) begin
          tape_we    = 1'b1;
          tape_wdata = tape_q + CW'(1);
          adv        = 1'b1;
        end else if (prog_q == bfm_pkg::CH_MINUS) begin
          tape_we    = 1'b1;
          tape_wdata = tape_q - CW'(1);
          adv        = 1'b1;
        end else if (prog_q == bfm_pkg::CH_RIGHT) begin
          dp_next = (dp == TAPE_LAST) ? '0 : dp + ONE_T;
          adv     = 1'b1;
        end else if (prog_q == bfm_pkg::CH_LEFT) begin
          dp_next = (dp == '0) ? TAPE_LAST : dp - ONE_T;
          adv     = 1'b1;
        end else if (prog_q == bfm_pkg::CH_LBRK && tape_q == '0) begin
          if (pc_inc >= len) begin
            err = 1'b1;
          end else begin
            k_next         = pc_inc;
            depth_next     = ONE_P;
            prog_re        = 1'b1;
            prog_raddr     = pc_inc[AW-1:0];
            stat.to_scan_f = 1'b1;
          end
        end else if (prog_q == bfm_pkg::CH_RBRK && tape_q != '0) begin
          if (pc == '0) begin
            err = 1'b1;
          end else begin
            k_next         = pc_dec;
            depth_next     = ONE_P;
            prog_re        = 1'b1;
            prog_raddr     = pc_dec[AW-1:0];
            stat.to_scan_b = 1'b1;
          end
        end else begin
          adv = 1'b1;
        end
      end
      bfm_pkg::DP_SCAN_F: begin
        priority if (depth_f == '0) begin
          adv           = 1'b1;
          tgt           = k_inc;
          stat.scan_end = 1'b1;
        end else if (k_inc >= len) begin
          err           = 1'b1;
          stat.scan_end = 1'b1;
        end else begin
          k_next     = k_inc;
          depth_next = depth_f;
          prog_re    = 1'b1;
          prog_raddr = k_inc[AW-1:0];
        end
      end
      bfm_pkg::DP_SCAN_B: begin
        priority if (depth_b == '0) begin
          adv           = 1'b1;
          tgt           = k_inc;
          stat.scan_end = 1'b1;
        end else if (k == '0) begin
          err           = 1'b1;
          stat.scan_end = 1'b1;
        end else begin
          k_next     = k_dec;
          depth_next = depth_b;
          prog_re    = 1'b1;
          prog_raddr = k_dec[AW-1:0];
        end
      end
      bfm_pkg::DP_CLR: begin
        tape_we       = 1'b1;
        tape_waddr    = clr_cnt;
        tape_wdata    = '0;
        stat.clr_last = (clr_cnt == TAPE_LAST);
        clr_cnt_next  = (clr_cnt == TAPE_LAST) ? '0 : clr_cnt + ONE_T;
      end
      bfm_pkg::DP_LOAD: begin
        out_valid_next = pend_ov;
        out_byte_next  = pend_ob;
        status_next    = pend_st;
      end
    endcase

    // end of an instruction: move pc, flag finish or bracket error
    if (adv) begin
      pc_next      = tgt;
      rs_next      = (tgt >= len) ? bfm_pkg::ST_FIN : bfm_pkg::ST_RUN;
      pend_st_next = (tgt >= len) ? bfm_pkg::ST_FIN : bfm_pkg::ST_RUN;
    end
    if (err) begin
      rs_next      = bfm_pkg::ST_UNMATCHED;
      pend_st_next = bfm_pkg::ST_UNMATCHED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      pc      <= '0;
      dp      <= '0;
      rs      <= bfm_pkg::ST_RUN;
      clr_cnt <= '0;
    end else begin
      len     <= len_next;
      pc      <= pc_next;
      dp      <= dp_next;
      rs      <= rs_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    k         <= k_next;
    depth     <= depth_next;
    mode_r    <= mode_r_next;
    byte_r    <= byte_r_next;
    pend_ov   <= pend_ov_next;
    pend_ob   <= pend_ob_next;
    pend_st   <= pend_st_next;
    out_valid <= out_valid_next;
    out_byte  <= out_byte_next;
    status    <= status_next;
  end

  always_ff @(posedge clk) begin
    if (prog_we) prog_mem[prog_waddr] <= prog_wdata;
    if (prog_re) prog_q <= prog_mem[prog_raddr];
  end

  always_ff @(posedge clk) begin
    if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
    if (tape_re) tape_q <= tape_mem[dp];
  end

endmodule

`default_nettype wire

### hw/rtl/brainfuck_machine_unit.sv
// ----------------------------------------------------------------------------
// brainfuck_machine_unit
// Brainfuck interpreter: program store, tape, one request per word.
//
// Each request word carries a mode: load one program byte (status 3 when the
// store is full), execute one instruction, start a run (tape cleared, program
// counter and data pointer zeroed), or clear the program. Every request gives
// exactly one response word with out_valid/out_byte for a dot and a status
// (0 running, 1 finished, 2 unmatched bracket, 3 store full). Tape cells are
// 32 bits and wrap; the data pointer wraps modulo TAPE_SIZE. Flow: a load
// or clear goes from accept through the start and result states, an
// instruction through start, execute and result, with a scan state between
// for a bracket jump (one read of the program store per cycle).
// A start-run zeroes the tape RAM one cell per cycle before the result.
// After reset the same pass runs with req_stall high. A new request is taken
// while the previous response still sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "brainfuck_machine_unit_defines.svh"

module brainfuck_machine_unit #(
  parameter int TAPE_SIZE  = 2048,
  parameter int PROG_DEPTH = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // request channel
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] prog_byte,
  // response channel
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic [1:0]      status
);

  bfm_pkg::dp_cmd_t  cmd;   // controller -> datapath
  bfm_pkg::dp_stat_t stat;  // datapath -> controller

  // state machine: intake, dispatch, bracket scan, tape clear, hand-off
  bfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // memories, pointers and the response payload registers
  bfm_dpath #(
    .TAPE_SIZE  (TAPE_SIZE),
    .PROG_DEPTH (PROG_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .mode      (mode),
    .prog_byte (prog_byte),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .status    (status)
  );

  // an accepted word is dispatched on the very next cycle
  `BMU_ASSERT_NEXT(a_accept_dispatch, clk, rst, req_valid && !req_stall, cmd.op == bfm_pkg::DP_START)
  // loading the output register always raises the response valid
  `BMU_ASSERT_NEXT(a_load_valid, clk, rst, cmd.op == bfm_pkg::DP_LOAD, rsp_valid)
  // an output byte only comes with a running or finished status
  `BMU_ASSERT_NOW(a_dot_status, clk, rst, rsp_valid && out_valid, status == bfm_pkg::ST_RUN || status == bfm_pkg::ST_FIN)
  // no dot, no byte
  `BMU_ASSERT_NOW(a_byte_zero, clk, rst, rsp_valid && !out_valid, out_byte == 8'd0)

endmodule

`default_nettype wire

### tb/tb.sv
// ============================================================================
// tb -- brainfuck_machine_unit request/response testbench
//
// Feeds request words (load byte, execute step, start run, clear program)
// through the valid/stall request channel and checks every response word
// against an in-bench model of the interpreter. The sender works in random
// bursts with random gaps. The receiver stalls on a randomly chosen pattern
// that changes over the run. The stimulus is a short directed opening, then
// random programs and noise.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPE_SIZE  = 2048;
  localparam int PROG_DEPTH = 4096;
  // Longest quiet stretch of a good run is a tape clear under receiver
  // stalls. Leave a wide margin over that.
  localparam int IDLE_LIMIT = 50000;
  localparam int MAX_PRINTS = 40;
  localparam int N_WORDS    = 900;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
  } req_word_t;

  typedef struct packed {
    logic       ov;
    logic [7:0] ob;
    logic [1:0] st;
  } rsp_word_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic [1:0] mode      = bfm_pkg::MODE_LOAD;
  logic [7:0] prog_byte = 8'h00;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [1:0] status;

  brainfuck_machine_unit #(
    .TAPE_SIZE (TAPE_SIZE),
    .PROG_DEPTH(PROG_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .mode     (mode),
    .prog_byte(prog_byte),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .out_valid(out_valid),
    .out_byte (out_byte),
    .status   (status)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Interpreter model state: our own copy of the machine.
  // --------------------------------------------------------------------------
  logic [7:0]  prog_mem [PROG_DEPTH];
  logic [31:0] tape_mem [TAPE_SIZE];
  logic [12:0] prog_len;
  logic [12:0] pc;
  logic [10:0] dptr;
  logic [1:0]  run_st;

  req_word_t   req_q[$];      // words waiting to be sent
  rsp_word_t   due_q[$];      // responses owed by the machine, oldest first
  logic [7:0]  prog_buf[$];   // program text under construction

  int bad_words   = 0;
  int rsp_count   = 0;
  int idle_cycles = 0;
  int gap_left    = 0;
  int burst_left  = 0;
  int stall_left  = 0;
  int stall_kind  = 0;

  // Apply one request word to the model and return the response it owes.
  function automatic rsp_word_t machine_step(logic [1:0] m, logic [7:0] b);
    rsp_word_t   r;
    logic [7:0]  op;
    logic [12:0] nxt;
    logic        found;
    logic        stuck;
    int          k;
    int          depth;
    r = '0;
    case (m)
      bfm_pkg::MODE_LOAD: begin
        if (prog_len < PROG_DEPTH) begin
          prog_mem[prog_len[11:0]] = b;
          prog_len = prog_len + 13'd1;
          r.st = bfm_pkg::ST_RUN;
        end else begin
          r.st = bfm_pkg::ST_FULL;   // byte dropped, reported for this word only
        end
      end
      bfm_pkg::MODE_STEP: begin
        if (run_st == bfm_pkg::ST_RUN) begin
          if (pc >= prog_len) begin
            run_st = bfm_pkg::ST_FIN;
          end else begin
            op    = prog_mem[pc[11:0]];
            nxt   = pc + 13'd1;
            stuck = 1'b0;
            case (op)
              bfm_pkg::CH_DOT: begin
                r.ov = 1'b1;
                r.ob = tape_mem[dptr][7:0];
              end
              bfm_pkg::CH_PLUS:  tape_mem[dptr] = tape_mem[dptr] + 32'd1;
              bfm_pkg::CH_MINUS: tape_mem[dptr] = tape_mem[dptr] - 32'd1;
              bfm_pkg::CH_RIGHT:
                dptr = (dptr == TAPE_SIZE - 1) ? 11'd0 : dptr + 11'd1;
              bfm_pkg::CH_LEFT:
                dptr = (dptr == 0) ? 11'(TAPE_SIZE - 1) : dptr - 11'd1;
              bfm_pkg::CH_LBRK: begin
                if (tape_mem[dptr] == 32'd0) begin
                  // forward scan for the matching close
                  depth = 1;
                  found = 1'b0;
                  k     = int'(pc) + 1;
                  while (k < prog_len && !found) begin
                    if (prog_mem[12'(k)] == bfm_pkg::CH_LBRK) depth++;
                    else if (prog_mem[12'(k)] == bfm_pkg::CH_RBRK) depth--;
                    if (depth == 0) found = 1'b1;
                    else k++;
                  end
                  if (found) nxt = 13'(k + 1);
                  else stuck = 1'b1;
                end
              end
              bfm_pkg::CH_RBRK: begin
                if (tape_mem[dptr] != 32'd0) begin
                  // backward scan for the matching open
                  depth = 1;
                  found = 1'b0;
                  k     = int'(pc);
                  while (k > 0 && !found) begin
                    k--;
                    if (prog_mem[12'(k)] == bfm_pkg::CH_RBRK) depth++;
                    else if (prog_mem[12'(k)] == bfm_pkg::CH_LBRK) depth--;
                    if (depth == 0) found = 1'b1;
                  end
                  if (found) nxt = 13'(k + 1);
                  else stuck = 1'b1;
                end
              end
              default: ;   // any other byte is a no-op
            endcase
            if (stuck) begin
              run_st = bfm_pkg::ST_UNMATCHED;   // pc stays on the bracket
            end else begin
              pc = nxt;
              if (pc >= prog_len) run_st = bfm_pkg::ST_FIN;
            end
          end
        end
        r.st = run_st;
      end
      bfm_pkg::MODE_RUN: begin
        tape_mem = '{default: 32'd0};
        pc       = '0;
        dptr     = '0;
        run_st   = bfm_pkg::ST_RUN;
        r.st     = bfm_pkg::ST_RUN;
      end
      default: begin
        // clear program: tape and data pointer survive
        prog_len = '0;
        pc       = '0;
        run_st   = bfm_pkg::ST_RUN;
        r.st     = bfm_pkg::ST_RUN;
      end
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string what, int unsigned got, int unsigned want);
    bad_words++;
    if (bad_words <= MAX_PRINTS)
      $display("MISMATCH word %0d %s: got %0h want %0h", rsp_count, what, got, want);
  endtask

  task automatic put(logic [1:0] m, logic [7:0] b);
    req_q.push_back('{mode: m, data: b});
  endtask

  // Any byte that is not a bracket.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == bfm_pkg::CH_LBRK || b == bfm_pkg::CH_RBRK);
    return b;
  endfunction

  // Append a random program fragment. Loops are "[> body <-]" so that they
  // count the entry cell down; nested loops take the same form. Bodies pick
  // no pointer moves, yet a random byte may be one; stray brackets are rare.
  task automatic emit_block(int lvl);
    int nseg, kind, reps, s;
    nseg = $urandom_range(1, 4);
    for (s = 0; s < nseg; s++) begin
      kind = $urandom_range(0, 9);
      reps = $urandom_range(1, 3);
      case (kind)
        0, 1: repeat (reps) prog_buf.push_back(bfm_pkg::CH_PLUS);
        2:    repeat (reps) prog_buf.push_back(bfm_pkg::CH_MINUS);
        3, 4: prog_buf.push_back(bfm_pkg::CH_DOT);
        5: begin
          if (lvl == 0)
            prog_buf.push_back($urandom_range(0, 1) ? bfm_pkg::CH_RIGHT : bfm_pkg::CH_LEFT);
          else prog_buf.push_back(bfm_pkg::CH_DOT);
        end
        6: begin
          if (lvl == 0 && $urandom_range(0, 5) == 0)
            prog_buf.push_back($urandom_range(0, 1) ? bfm_pkg::CH_LBRK : bfm_pkg::CH_RBRK);
          else
            prog_buf.push_back(plain_byte());
        end
        default: begin
          if (lvl < 2) begin
            prog_buf.push_back(bfm_pkg::CH_LBRK);
            prog_buf.push_back(bfm_pkg::CH_RIGHT);
            emit_block(lvl + 1);
            prog_buf.push_back(bfm_pkg::CH_LEFT);
            prog_buf.push_back(bfm_pkg::CH_MINUS);
            prog_buf.push_back(bfm_pkg::CH_RBRK);
          end else begin
            prog_buf.push_back(bfm_pkg::CH_PLUS);
          end
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: pops pending words, bursts and gaps at random, and runs the
  // model on every word the machine accepts.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drv
    req_word_t nxt_req;
    if (rst) begin
      req_valid  <= 1'b0;
      gap_left   <= 0;
      burst_left <= 0;
    end else begin
      if (req_valid && !req_stall) due_q.push_back(machine_step(mode, prog_byte));
      // a held word stays put until it is taken
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          req_valid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (req_q.size() > 0) begin
          nxt_req   = req_q.pop_front();
          req_valid <= 1'b1;
          mode      <= nxt_req.mode;
          prog_byte <= nxt_req.data;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            // a quarter of bursts run straight into the next one
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: switches at random between no stall, light, heavy and
  // periodic stalling.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
      stall_kind <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_kind <= $urandom_range(0, 3);
        stall_left <= $urandom_range(32, 256);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_kind)
        0:       rsp_stall <= 1'b0;
        1:       rsp_stall <= ($urandom_range(0, 3) == 0);
        2:       rsp_stall <= ($urandom_range(0, 3) != 0);
        default: rsp_stall <= stall_left[2];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every accepted response word against the oldest one owed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    rsp_word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_q.size() == 0) begin
        note_mismatch("response with none owed", {out_valid, out_byte, status}, 0);
      end else begin
        want = due_q.pop_front();
        if (out_valid !== want.ov) note_mismatch("out_valid", out_valid, want.ov);
        if (out_byte !== want.ob) note_mismatch("out_byte", out_byte, want.ob);
        if (status !== want.st) note_mismatch("status", status, want.st);
      end
      rsp_count++;
    end
  end

  // Watchdog: too long without any word moving on either channel.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int target, nsteps, i, pick;
    tape_mem = '{default: 32'd0};
    prog_mem = '{default: 8'h00};
    prog_len = '0;
    pc       = '0;
    dptr     = '0;
    run_st   = bfm_pkg::ST_RUN;

    // Directed: step on an empty program finishes at once.
    put(bfm_pkg::MODE_STEP, 8'h00);
    // "-.<++[-].>" style walk: wrap to all ones and print 0xFF, pointer
    // wraps below zero, loop jumps back once, pointer wraps above the top,
    // and the last instruction finishes the run.
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_MINUS);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_DOT);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_LEFT);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_PLUS);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_PLUS);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_LBRK);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_MINUS);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_RBRK);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_DOT);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_RIGHT);
    put(bfm_pkg::MODE_RUN, 8'hFF);
    repeat (13) put(bfm_pkg::MODE_STEP, 8'h00);   // last one steps after the halt
    // close bracket with nothing to match
    put(bfm_pkg::MODE_CLEAR, 8'hA5);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_PLUS);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_RBRK);
    put(bfm_pkg::MODE_RUN, 8'h5A);
    put(bfm_pkg::MODE_STEP, 8'h00);
    put(bfm_pkg::MODE_STEP, 8'h00);

    // Open bracket on a zero cell and no close: the scan runs off the end.
    put(bfm_pkg::MODE_CLEAR, 8'h00);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_LBRK);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_DOT);
    put(bfm_pkg::MODE_LOAD, bfm_pkg::CH_PLUS);
    put(bfm_pkg::MODE_RUN, 8'h00);
    put(bfm_pkg::MODE_STEP, 8'h00);
    put(bfm_pkg::MODE_STEP, 8'h00);
    put(bfm_pkg::MODE_CLEAR, 8'hFF);

    // Random: mostly whole programs run for a while, some raw noise.
    target = N_WORDS;
    while (req_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if ($urandom_range(0, 4) != 0)
          put(bfm_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)));
        prog_buf.delete();
        emit_block(0);
        for (i = 0; i < prog_buf.size(); i++) put(bfm_pkg::MODE_LOAD, prog_buf[i]);
        if ($urandom_range(0, 5) != 0) put(bfm_pkg::MODE_RUN, 8'($urandom_range(0, 255)));
        nsteps = $urandom_range(prog_buf.size(), 3 * prog_buf.size() + 8);
        if (nsteps > 150) nsteps = 150;
        for (i = 0; i < nsteps; i++) begin
          // now and then the program grows while it runs
          if ($urandom_range(0, 29) == 0)
            put(bfm_pkg::MODE_LOAD, $urandom_range(0, 1) ? bfm_pkg::CH_DOT : bfm_pkg::CH_PLUS);
          else
            put(bfm_pkg::MODE_STEP, 8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          put(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all sent, then all owed responses back; a lost one trips the watchdog
    while (req_q.size() != 0 || req_valid) @(posedge clk);
    while (due_q.size() != 0) @(posedge clk);
    // room for any stray extra response to show up
    repeat (50) @(posedge clk);

    if (bad_words == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
